[rtl/nearest_palette_color_l1_assert.svh]
// assertion macros used by the checker file npc_check
// no dependencies; include by bare file name
`ifndef NEAREST_PALETTE_COLOR_L1_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_L1_ASSERT_SVH

// clocked assertion, masked while reset is high
`define NPC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// clocked assertion that also holds through reset
`define NPC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/npc_pkg.sv]
// types, constants, palette rom and helpers for the nearest palette color block
// no dependencies; used by every rtl module but npc_check
package npc_pkg;

   localparam int PALETTE_MAX = 32;
   localparam int CH_W        = 8;
   localparam int SCALE_W     = 8;
   localparam int IDX_W       = 5;
   localparam int DIGIT_W     = 7;
   localparam int DIST_W      = 10;
   localparam int GROUP_SIZE  = 8;
   localparam int GROUPS      = PALETTE_MAX / GROUP_SIZE;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd1;
   localparam logic [CH_W-1:0]    CH_MAX      = 8'd255;
   // unused palette slots carry a distance no real entry can reach
   localparam logic [DIST_W-1:0]  DIST_PAD    = 10'h3FF;
   localparam logic [IDX_W-1:0]   DECIMAL_DIGITS = 5'd10;
   localparam logic [DIGIT_W-1:0] DIGIT_ZERO  = 7'd48;   // '0'
   localparam logic [DIGIT_W-1:0] DIGIT_ALPHA = 7'd87;   // 'a' minus ten

   typedef logic [CH_W-1:0] chan_type;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
   } pixel_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [IDX_W-1:0]  idx;
   } cand_type;

   typedef struct packed {
      logic [DIST_W-1:0]  best_distance;
      logic [DIGIT_W-1:0] digit_char;
      logic [IDX_W-1:0]   palette_index;
   } result_type;

   // red in the top byte, blue in the low byte
   localparam pixel_type PALETTE_ROM [PALETTE_MAX] = '{
      24'h000000, 24'hFFFFFF, 24'hAAAAAA, 24'h555555,
      24'hFED3C7, 24'hFFC4CE, 24'hFAAC8E, 24'hFF8B83,
      24'hF44336, 24'hE91E63, 24'hE2669E, 24'h9C27B0,
      24'h673AB7, 24'h3F51B5, 24'h004670, 24'h057197,
      24'h2196F3, 24'h00BCD4, 24'h3BE5DB, 24'h97FDDC,
      24'h167300, 24'h37A93C, 24'h89E642, 24'hD7FF07,
      24'hFFF6D1, 24'hF8CB8C, 24'hFFEB3B, 24'hFFC107,
      24'hFF9800, 24'hFF5722, 24'hB83F27, 24'h795548
   };

   function automatic chan_type abs_diff(input chan_type a, input chan_type b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   function automatic logic [DIGIT_W-1:0] index_digit(input logic [IDX_W-1:0] idx);
      logic [DIGIT_W-1:0] wide;
      wide = DIGIT_W'(idx);
      return (idx < DECIMAL_DIGITS) ? (DIGIT_ZERO + wide) : (DIGIT_ALPHA + wide);
   endfunction

endpackage

[rtl/npc_scale.sv]
// first pipeline stage: per-channel scale multiply with saturation to 8 bits
// depends on npc_pkg
module npc_scale (
   input  logic                            clock,
   input  logic                            load,
   input  npc_pkg::pixel_type              pix_in,
   input  logic [npc_pkg::SCALE_W-1:0]     scale,
   output npc_pkg::pixel_type              pix_ff
);

   npc_pkg::pixel_type pix_in_s;

   function automatic npc_pkg::chan_type scale_sat(input npc_pkg::chan_type raw,
                                                   input logic [npc_pkg::SCALE_W-1:0] k);
      logic [npc_pkg::CH_W+npc_pkg::SCALE_W-1:0] prod;
      prod = (npc_pkg::CH_W+npc_pkg::SCALE_W)'(raw) * (npc_pkg::CH_W+npc_pkg::SCALE_W)'(k);
      return (prod > (npc_pkg::CH_W+npc_pkg::SCALE_W)'(npc_pkg::CH_MAX)) ?
             npc_pkg::CH_MAX : prod[npc_pkg::CH_W-1:0];
   endfunction

   always_comb begin
      pix_in_s.red   = scale_sat(pix_in.red, scale);
      pix_in_s.green = scale_sat(pix_in.green, scale);
      pix_in_s.blue  = scale_sat(pix_in.blue, scale);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff <= pix_in_s;
      end
   end

endmodule

[rtl/npc_dist.sv]
// second pipeline stage: manhattan distance to every palette entry in parallel
// depends on npc_pkg (palette rom, abs_diff)
module npc_dist #(
   parameter int PALETTE_ENTRIES = npc_pkg::PALETTE_MAX
) (
   input  logic                          clock,
   input  logic                          load,
   input  npc_pkg::pixel_type            pix,
   output logic [npc_pkg::DIST_W-1:0]    dist_ff [npc_pkg::PALETTE_MAX]
);

   for (genvar i = 0; i < npc_pkg::PALETTE_MAX; i++) begin : g_entry
      logic [npc_pkg::DIST_W-1:0] dist_in;

      if (i < PALETTE_ENTRIES) begin : g_live
         always_comb begin
            dist_in = npc_pkg::DIST_W'(npc_pkg::abs_diff(pix.red,
                                                         npc_pkg::PALETTE_ROM[i].red))
                    + npc_pkg::DIST_W'(npc_pkg::abs_diff(pix.green,
                                                         npc_pkg::PALETTE_ROM[i].green))
                    + npc_pkg::DIST_W'(npc_pkg::abs_diff(pix.blue,
                                                         npc_pkg::PALETTE_ROM[i].blue));
         end
      end else begin : g_pad
         assign dist_in = npc_pkg::DIST_PAD;
      end

      always_ff @(posedge clock) begin
         if (load) begin
            dist_ff[i] <= dist_in;
         end
      end
   end

endmodule

[rtl/npc_min.sv]
// third and fourth pipeline stages: lowest-index minimum over the distances
// groups of eight are scanned in stage three, the group winners in stage four
// depends on npc_pkg
module npc_min (
   input  logic                          clock,
   input  logic                          load_grp,
   input  logic                          load_out,
   input  logic [npc_pkg::DIST_W-1:0]    dist_all [npc_pkg::PALETTE_MAX],
   output npc_pkg::result_type           result_ff
);

   npc_pkg::cand_type   grp_in [npc_pkg::GROUPS];
   npc_pkg::cand_type   grp_ff [npc_pkg::GROUPS];
   npc_pkg::cand_type   best_s;
   npc_pkg::result_type result_in;

   // strict less-than keeps the earlier entry on a tie
   always_comb begin
      for (int g = 0; g < npc_pkg::GROUPS; g++) begin
         grp_in[g].distance = dist_all[g*npc_pkg::GROUP_SIZE];
         grp_in[g].idx      = npc_pkg::IDX_W'(g*npc_pkg::GROUP_SIZE);
         for (int k = 1; k < npc_pkg::GROUP_SIZE; k++) begin
            if (dist_all[g*npc_pkg::GROUP_SIZE+k] < grp_in[g].distance) begin
               grp_in[g].distance = dist_all[g*npc_pkg::GROUP_SIZE+k];
               grp_in[g].idx      = npc_pkg::IDX_W'(g*npc_pkg::GROUP_SIZE+k);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_grp) begin
         grp_ff <= grp_in;
      end
   end

   always_comb begin
      best_s = grp_ff[0];
      for (int g = 1; g < npc_pkg::GROUPS; g++) begin
         if (grp_ff[g].distance < best_s.distance) begin
            best_s = grp_ff[g];
         end
      end
      result_in.best_distance = best_s.distance;
      result_in.palette_index = best_s.idx;
      result_in.digit_char    = npc_pkg::index_digit(best_s.idx);
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         result_ff <= result_in;
      end
   end

endmodule

[rtl/nearest_palette_color_l1.sv]
// nearest palette color, manhattan distance, four-stage pipeline
// req_* carries one rgb pixel a beat, rsp_* one result a beat; csr_* writes the
// channel scale (multiplier, normally 256 / (maxval + 1)); csr_ready is always high.
// each channel is scaled and clamped to 255, then compared against a fixed
// 32-color rom; the nearest entry wins, the lowest index on a tie.
// stages: scale multiply, parallel distances, scan of groups of eight,
// scan of four group winners into the output register.
// a pixel accepted into the scale register moves on through the distance,
// group and output registers and then shows its result on rsp_tvalid. throughput:
// one beat per cycle while the receiver keeps taking results, set by the pipeline
// having a register per stage and a valid bit traveling with each.
// when the receiver stalls, each stage holds once the stage ahead is full;
// req_tready drops only when every stage holds a beat. nothing is dropped.
// reset clears all valid bits and sets the scale to one. the scale may be
// written only when the pipeline is empty.
// depends on npc_pkg, npc_scale, npc_dist, npc_min
module nearest_palette_color_l1 #(
   parameter int PALETTE_ENTRIES = npc_pkg::PALETTE_MAX
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red[7:0], green[15:8], blue[23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // palette_index[4:0], digit_char[11:5],
                                    // best_distance[21:12], zero[23:22]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_wdata    // channel_scale
);

   logic [npc_pkg::SCALE_W-1:0] scale_ff;
   logic                        s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                        s1_ready, s2_ready, s3_ready, s4_ready;
   npc_pkg::pixel_type          pix_in;
   npc_pkg::pixel_type          scaled_ff;
   logic [npc_pkg::DIST_W-1:0]  dist_ff [npc_pkg::PALETTE_MAX];
   npc_pkg::result_type         result_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= npc_pkg::SCALE_RESET;
      end else if (csr_valid) begin
         scale_ff <= csr_wdata;
      end
   end

   // a stage loads when it is empty or its beat moves on
   assign s4_ready = !s4_valid_ff || rsp_tready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_tvalid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_comb begin
      pix_in.red   = req_tdata[7:0];
      pix_in.green = req_tdata[15:8];
      pix_in.blue  = req_tdata[23:16];
   end

   npc_scale u_scale (
      .clock  (clock),
      .load   (s1_ready),
      .pix_in (pix_in),
      .scale  (scale_ff),
      .pix_ff (scaled_ff)
   );

   npc_dist #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_dist (
      .clock   (clock),
      .load    (s2_ready),
      .pix     (scaled_ff),
      .dist_ff (dist_ff)
   );

   npc_min u_min (
      .clock     (clock),
      .load_grp  (s3_ready),
      .load_out  (s4_ready),
      .dist_all  (dist_ff),
      .result_ff (result_ff)
   );

   assign rsp_tvalid = s4_valid_ff;
   assign rsp_tdata  = {2'b00, result_ff.best_distance, result_ff.digit_char,
                        result_ff.palette_index};

endmodule

[rtl/npc_check.sv]
// port-level checker for nearest_palette_color_l1, attached by bind
// depends on nearest_palette_color_l1_assert.svh
`include "nearest_palette_color_l1_assert.svh"

module npc_check (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   `NPC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "output valid after reset")

   `NPC_ASSERT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   `NPC_ASSERT(a_digit_match, clock, reset, rsp_tvalid |-> (rsp_tdata[4:0] < 5'd10 && rsp_tdata[11:5] == 7'd48 + 7'(rsp_tdata[4:0])) || (rsp_tdata[4:0] >= 5'd10 && rsp_tdata[11:5] == 7'd87 + 7'(rsp_tdata[4:0])), "digit does not match index")

   `NPC_ASSERT(a_dist_range, clock, reset, rsp_tvalid |-> rsp_tdata[21:12] <= 10'd765 && rsp_tdata[23:22] == 2'b00, "distance out of range")

endmodule

bind nearest_palette_color_l1 npc_check u_npc_check (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[test/tb_nearest_palette_color_l1.sv]
// testbench for nearest_palette_color_l1: streams rgb pixels under several channel scales
// and checks palette index, digit and distance against a built-in predictor
// depends on nearest_palette_color_l1 and its rtl files (npc_pkg and the stage modules)
`timescale 1ns / 100ps

module tb_nearest_palette_color_l1;

   localparam int SWATCH_COUNT     = 32;
   localparam int DECIMAL_DIGITS   = 10;
   localparam int ASCII_ZERO       = 48;
   localparam int ASCII_A_LESS_TEN = 87;
   localparam int PIPE_DEPTH       = 4;
   localparam int MAX_SHOWN        = 10;
   localparam int CYCLE_LIMIT      = 500000;
   localparam int PHASE_PIXELS     = 130;
   localparam int PHASES           = 14;
   localparam int RANDOM_SCALE     = -1;

   // palette colors as red, green, blue
   localparam int SWATCH_R [SWATCH_COUNT] = '{
      0, 255, 170, 85, 254, 255, 250, 255, 244, 233, 226, 156, 103, 63, 0, 5,
      33, 0, 59, 151, 22, 55, 137, 215, 255, 248, 255, 255, 255, 255, 184, 121};
   localparam int SWATCH_G [SWATCH_COUNT] = '{
      0, 255, 170, 85, 211, 196, 172, 139, 67, 30, 102, 39, 58, 81, 70, 113,
      150, 188, 229, 253, 115, 169, 230, 255, 246, 203, 235, 193, 152, 87, 63, 85};
   localparam int SWATCH_B [SWATCH_COUNT] = '{
      0, 255, 170, 85, 199, 206, 142, 131, 54, 99, 158, 176, 183, 181, 112, 151,
      243, 212, 219, 220, 0, 60, 66, 7, 209, 140, 59, 7, 0, 34, 39, 72};

   typedef struct {
      logic [4:0] index;
      logic [6:0] digit;
      logic [9:0] distance;
   } swatch_match_type;

   typedef enum int { RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_BLOCKED } rx_mode_type;
   typedef enum int { PIX_IN_RANGE, PIX_NEAR_SWATCH, PIX_ANY } pixel_kind_type;

   class palette_scoreboard;
      logic [7:0] scale;
      swatch_match_type awaiting[$];
      int pixels;
      int checked;
      int errors;
      int ties;

      function new();
         scale   = 8'd1;
         pixels  = 0;
         checked = 0;
         errors  = 0;
         ties    = 0;
      endfunction

      function void set_scale(logic [7:0] value);
         scale = value;
      endfunction

      function int pending();
         return awaiting.size();
      endfunction

      function int scaled(logic [7:0] raw);
         logic [15:0] product;
         product = 16'(raw) * 16'(scale);
         return (product > 16'd255) ? 255 : int'(product);
      endfunction

      function swatch_match_type closest_swatch(logic [7:0] r, logic [7:0] g, logic [7:0] b);
         swatch_match_type m;
         int sr, sg, sb, d, best, best_d;
         sr = scaled(r);
         sg = scaled(g);
         sb = scaled(b);
         best   = 0;
         best_d = 'hFFFF;
         for (int i = 0; i < SWATCH_COUNT; i++) begin
            d = ((sr >= SWATCH_R[i]) ? sr - SWATCH_R[i] : SWATCH_R[i] - sr)
              + ((sg >= SWATCH_G[i]) ? sg - SWATCH_G[i] : SWATCH_G[i] - sg)
              + ((sb >= SWATCH_B[i]) ? sb - SWATCH_B[i] : SWATCH_B[i] - sb);
            if (d < best_d) begin
               best_d = d;
               best   = i;
            end else if (d == best_d) begin
               ties++;
            end
         end
         m.index    = 5'(best);
         m.digit    = 7'((best < DECIMAL_DIGITS) ? ASCII_ZERO + best : ASCII_A_LESS_TEN + best);
         m.distance = 10'(best_d);
         return m;
      endfunction

      function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
         awaiting.push_back(closest_swatch(r, g, b));
         pixels++;
      endfunction

      function void check_result(logic [23:0] beat);
         swatch_match_type want;
         logic [4:0] got_index;
         logic [6:0] got_digit;
         logic [9:0] got_dist;
         got_index = beat[4:0];
         got_digit = beat[11:5];
         got_dist  = beat[21:12];
         if (awaiting.size() == 0) begin
            errors++;
            if (errors <= MAX_SHOWN)
               $display("unexpected result beat: idx %0d char %0d dist %0d",
                        got_index, got_digit, got_dist);
            return;
         end
         want = awaiting.pop_front();
         if (got_index !== want.index || got_digit !== want.digit
             || got_dist !== want.distance) begin
            errors++;
            if (errors <= MAX_SHOWN)
               $display("mismatch at result %0d: want idx %0d char %0d dist %0d, got idx %0d char %0d dist %0d",
                        checked, want.index, want.digit, want.distance,
                        got_index, got_digit, got_dist);
         end
         checked++;
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // red[7:0], green[15:8], blue[23:16]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // palette_index[4:0], digit_char[11:5],
                                   // best_distance[21:12], zero[23:22]
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_wdata  = '0;

   palette_scoreboard book = new();
   int cycles = 0;
   int scale_writes = 0;
   int burst_left = 0;
   bit steady = 1'b0;
   int rx_tick = 0;
   rx_mode_type rx_mode = RX_OPEN;

   nearest_palette_color_l1 DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still pending", cycles, book.pending());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // sample every handshake on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            book.set_scale(csr_wdata);
         if (req_tvalid && req_tready)
            book.note_pixel(req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]);
         if (rsp_tvalid && rsp_tready)
            book.check_result(rsp_tdata);
      end
   end

   // receiver backpressure, pattern picked at random from four modes
   always @(negedge clock) begin
      rx_tick++;
      if (rx_tick % 64 == 0)
         rx_mode = rx_mode_type'($urandom_range(0, 3));
      case (rx_mode)
         RX_OPEN:     rsp_tready <= 1'b1;
         RX_RANDOM:   rsp_tready <= ($urandom_range(0, 3) != 0);
         RX_PERIODIC: rsp_tready <= (rx_tick % 8 != 0);
         default:     rsp_tready <= ((rx_tick / 16) % 2 == 0);
      endcase
   end

   // all driving tasks start and end on a falling edge
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      req_tdata  <= {b, g, r};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         if (!steady) begin
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (book.pending() != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 2) @(negedge clock);
   endtask

   task automatic write_scale(input logic [7:0] value);
      wait_idle();
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      scale_writes++;
   endtask

   task automatic paced_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      pace();
      send_pixel(r, g, b);
   endtask

   function automatic logic [7:0] draw_sample(input logic [7:0] scale,
                                              input pixel_kind_type kind, input int aim);
      int top, v, jitter;
      top = (scale == 8'd0) ? 255 : 256 / scale - 1;
      case (kind)
         PIX_IN_RANGE: v = $urandom_range(0, top);
         PIX_NEAR_SWATCH: begin
            jitter = $urandom_range(0, 2);
            v = ((scale == 8'd0) ? aim : aim / scale) + jitter - 1;
         end
         default: v = $urandom_range(0, 255);
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   initial begin
      int scale_plan [PHASES] = '{1, 2, 4, 8, 16, 32, 64, 128, 3, 85, 0, 255,
                                  RANDOM_SCALE, RANDOM_SCALE};
      logic [7:0] scale;
      pixel_kind_type kind;
      int k, roll;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset scale of one: extremes, exact palette hits, a tie between two yellows
      steady = 1'b1;
      paced_pixel(8'd0, 8'd0, 8'd0);
      paced_pixel(8'd255, 8'd255, 8'd255);
      paced_pixel(8'd255, 8'd0, 8'd0);
      paced_pixel(8'd0, 8'd255, 8'd0);
      paced_pixel(8'd0, 8'd0, 8'd255);
      paced_pixel(8'd244, 8'd67, 8'd54);
      paced_pixel(8'd254, 8'd211, 8'd199);
      paced_pixel(8'd121, 8'd85, 8'd72);
      paced_pixel(8'd255, 8'd214, 8'd33);
      paced_pixel(8'd128, 8'd128, 8'd128);
      paced_pixel(8'd170, 8'd170, 8'd171);

      // zero scale turns every pixel black
      write_scale(8'd0);
      paced_pixel(8'd255, 8'd255, 8'd255);
      paced_pixel(8'd0, 8'd128, 8'd1);

      // largest scale saturates any nonzero sample
      write_scale(8'd255);
      paced_pixel(8'd1, 8'd1, 8'd1);
      paced_pixel(8'd2, 8'd0, 8'd1);
      paced_pixel(8'd0, 8'd1, 8'd0);

      // top of the normal range, one step over maxval clamps
      write_scale(8'd128);
      paced_pixel(8'd1, 8'd1, 8'd0);
      paced_pixel(8'd2, 8'd1, 8'd0);
      paced_pixel(8'd255, 8'd255, 8'd255);

      for (int p = 0; p < PHASES; p++) begin
         scale = (scale_plan[p] == RANDOM_SCALE) ? 8'($urandom_range(0, 255))
                                                 : 8'(scale_plan[p]);
         steady = ($urandom_range(0, 3) == 0);
         write_scale(scale);
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            if ($urandom_range(0, 199) == 0)
               wait_idle();
            roll = $urandom_range(0, 9);
            kind = (roll < 6) ? PIX_IN_RANGE : (roll < 8) ? PIX_NEAR_SWATCH : PIX_ANY;
            k = $urandom_range(0, SWATCH_COUNT - 1);
            paced_pixel(draw_sample(scale, kind, SWATCH_R[k]),
                        draw_sample(scale, kind, SWATCH_G[k]),
                        draw_sample(scale, kind, SWATCH_B[k]));
         end
      end

      wait_idle();
      repeat (PIPE_DEPTH * 2) @(negedge clock);

      $display("covered %0d pixels over %0d scale writes (zero, one, 128, 255 among them)",
               book.pixels, scale_writes);
      $display("checked %0d results, %0d equal-distance candidates seen, %0d mismatches",
               book.checked, book.ties, book.errors);
      if (book.errors == 0 && book.pending() == 0 && book.checked == book.pixels) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
